[rtl/drkr_pkg.sv]
// ----------------------------------------------------------------------------
// drkr_pkg
// Shared types, event codes and helper functions of the dual-role key remapper.
// ----------------------------------------------------------------------------
package drkr_pkg;

   localparam logic [4:0] EVT_SYN = 5'd0;
   localparam logic [4:0] EVT_KEY = 5'd1;
   localparam logic [4:0] EVT_REL = 5'd2;
   localparam logic [4:0] EVT_ABS = 5'd3;
   localparam logic [4:0] EVT_MSC = 5'd4;

   localparam logic [9:0] MSC_SCAN_CODE = 10'd4;
   localparam logic [9:0] KEY_ESC       = 10'd1;
   localparam logic [9:0] KEY_BACKTICK  = 10'd41;
   localparam logic [9:0] KEY_CAPS      = 10'd58;
   localparam logic [9:0] KEY_LCTRL     = 10'd29;
   localparam logic [9:0] KEY_LMETA     = 10'd125;

   localparam logic [1:0]  MODE_ESC_TO_CAPS   = 2'd0;
   localparam logic [1:0]  MODE_ESC_TO_GRAVE  = 2'd2;
   localparam logic [19:0] DEFAULT_DELAY_US   = 20'd20000;

   localparam logic [1:0] CSR_REMAP_MODE = 2'd0;
   localparam logic [1:0] CSR_USE_SUPER  = 2'd1;
   localparam logic [1:0] CSR_DELAY_US   = 2'd2;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_HELD = 2'd1,
      PH_MOD  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      CMD_SINGLE = 2'd0,
      CMD_TAP    = 2'd1,
      CMD_PREFIX = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [4:0]         ev_type;
      logic [9:0]         ev_code;
      logic signed [31:0] ev_value;
   } cmd_type;

   function automatic logic [9:0] remap_code(input logic [4:0] ev_type,
                                             input logic [9:0] ev_code,
                                             input logic [1:0] mode);
      logic [9:0] res;
      res = ev_code;
      if (ev_type == EVT_KEY) begin
         if (mode == MODE_ESC_TO_CAPS) begin
            if (ev_code == KEY_ESC) res = KEY_CAPS;
         end else if (mode == MODE_ESC_TO_GRAVE) begin
            if (ev_code == KEY_ESC) res = KEY_BACKTICK;
            else if (ev_code == KEY_BACKTICK) res = KEY_CAPS;
         end
      end
      return res;
   endfunction

   function automatic logic [9:0] modifier_code(input logic use_super);
      return use_super ? KEY_LMETA : KEY_LCTRL;
   endfunction

endpackage

[rtl/drkr_front.sv]
// ----------------------------------------------------------------------------
// drkr_front
// Accepts input events, tracks the caps phase and classifies each event into
// a command for the back end, or drops it.
// ----------------------------------------------------------------------------
module drkr_front
   import drkr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [4:0]         req_ev_type,
   input  logic [9:0]         req_ev_code,
   input  logic signed [31:0] req_ev_value,
   input  logic [1:0]         remap_mode,
   input  logic               use_super,
   input  logic               q_full,
   output logic               push,
   output cmd_type            push_cmd
);

   phase_type phase_ff, phase_in;
   logic      accept;
   logic      keep;
   logic      is_caps;
   logic      is_motion;
   logic      val_zero;
   logic [9:0] mapped;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign push      = accept && keep;

   always_comb begin
      is_caps   = (req_ev_type == EVT_KEY) && (req_ev_code == KEY_CAPS);
      is_motion = (req_ev_type == EVT_REL) || (req_ev_type == EVT_ABS);
      val_zero  = (req_ev_value == 32'sd0);
      mapped    = remap_code(req_ev_type, req_ev_code, remap_mode);

      phase_in          = phase_ff;
      keep              = 1'b1;
      push_cmd.kind     = CMD_SINGLE;
      push_cmd.ev_type  = req_ev_type;
      push_cmd.ev_code  = mapped;
      push_cmd.ev_value = req_ev_value;

      if ((req_ev_type == EVT_MSC) && (req_ev_code == MSC_SCAN_CODE)) begin
         keep = 1'b0;
      end else if ((req_ev_type != EVT_KEY) && !is_motion) begin
         keep = 1'b1;
      end else begin
         unique case (phase_ff)
            PH_HELD: begin
               if (is_caps) begin
                  if (val_zero) begin
                     push_cmd.kind = CMD_TAP;
                     phase_in      = PH_IDLE;
                  end else begin
                     keep = 1'b0;
                  end
               end else if (((req_ev_type == EVT_KEY) && (req_ev_value == 32'sd1))
                            || is_motion) begin
                  push_cmd.kind = CMD_PREFIX;
                  phase_in      = PH_MOD;
               end
            end
            PH_MOD: begin
               if (is_caps) begin
                  push_cmd.ev_code = modifier_code(use_super);
                  if (val_zero) phase_in = PH_IDLE;
               end
            end
            default: begin
               if (is_caps && !val_zero) begin
                  keep     = 1'b0;
                  phase_in = PH_HELD;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else if (accept) begin
         phase_ff <= phase_in;
      end
   end

endmodule

[rtl/drkr_queue.sv]
// ----------------------------------------------------------------------------
// drkr_queue
// Short command queue between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module drkr_queue
   import drkr_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output cmd_type head_cmd
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   cmd_type         slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

[rtl/drkr_back.sv]
// ----------------------------------------------------------------------------
// drkr_back
// Steps through each queued command and emits its result events, one per
// cycle unless rsp_stall holds the output, into a registered output stage.
// ----------------------------------------------------------------------------
module drkr_back
   import drkr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  cmd_type            head_cmd,
   output logic               pop,
   input  logic               use_super,
   input  logic [19:0]        delay_us,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [4:0]         rsp_out_type,
   output logic [9:0]         rsp_out_code,
   output logic signed [31:0] rsp_out_value,
   output logic [19:0]        rsp_wait_after_us,
   output logic               rsp_last_of_run
);

   logic               valid_ff, valid_in;
   logic [1:0]         step_ff, step_in;
   logic [4:0]         type_ff, type_in;
   logic [9:0]         code_ff, code_in;
   logic signed [31:0] value_ff, value_in;
   logic [19:0]        wait_ff, wait_in;
   logic               last_ff, last_in;
   logic               load;

   assign load = head_valid && (!valid_ff || !rsp_stall);
   assign pop  = load && last_in;

   always_comb begin
      type_in  = head_cmd.ev_type;
      code_in  = head_cmd.ev_code;
      value_in = head_cmd.ev_value;
      wait_in  = '0;
      last_in  = 1'b1;
      unique case (head_cmd.kind)
         CMD_TAP, CMD_PREFIX: begin
            last_in = (step_ff == 2'd2);
            if (step_ff == 2'd0) begin
               type_in  = EVT_KEY;
               code_in  = (head_cmd.kind == CMD_TAP) ? KEY_ESC : modifier_code(use_super);
               value_in = 32'sd1;
            end else if (step_ff == 2'd1) begin
               type_in  = EVT_SYN;
               code_in  = '0;
               value_in = 32'sd0;
               wait_in  = delay_us;
            end else if (head_cmd.kind == CMD_TAP) begin
               type_in  = EVT_KEY;
               code_in  = KEY_ESC;
               value_in = 32'sd0;
            end
         end
         default: begin
            last_in = 1'b1;
         end
      endcase

      if (load) valid_in = 1'b1;
      else if (!rsp_stall) valid_in = 1'b0;
      else valid_in = valid_ff;

      if (load) step_in = last_in ? 2'd0 : step_ff + 2'd1;
      else step_in = step_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         type_ff  <= type_in;
         code_ff  <= code_in;
         value_ff <= value_in;
         wait_ff  <= wait_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_type      = type_ff;
   assign rsp_out_code      = code_ff;
   assign rsp_out_value     = value_ff;
   assign rsp_wait_after_us = wait_ff;
   assign rsp_last_of_run   = last_ff;

endmodule

[rtl/dual_role_key_remapper_unit.sv]
// ----------------------------------------------------------------------------
// dual_role_key_remapper_unit
// Caps lock tap/hold remapper for input events with escape/grave remapping.
// ----------------------------------------------------------------------------
//   channel | direction | handshake           | carries
//   req_    | in        | req_valid/req_stall | ev_type, ev_code, ev_value
//   rsp_    | out       | rsp_valid/rsp_stall | out_type, out_code, out_value,
//           |           |                     | wait_after_us, last_of_run
//   csr_    | in        | csr_write           | csr_index, csr_wdata
//
// An event that gives one result passes as a single command; a tap or a
// modifier prefix gives three results, which the result sequencer emits in turn.
// A command is registered in a queue slot and then in the output register.
// Reset is synchronous; it clears the caps phase, the queue and the output
// stage and loads the register defaults. No clearing pass is needed.
// req_stall rises only when the command queue is full; rsp_stall holds the
// output register and, once the queue fills, the input side.
// ----------------------------------------------------------------------------
module dual_role_key_remapper_unit
   import drkr_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [4:0]         req_ev_type,
   input  logic [9:0]         req_ev_code,
   input  logic signed [31:0] req_ev_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [4:0]         rsp_out_type,
   output logic [9:0]         rsp_out_code,
   output logic signed [31:0] rsp_out_value,
   output logic [19:0]        rsp_wait_after_us,
   output logic               rsp_last_of_run,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [19:0]        csr_wdata
);

   logic [1:0]  remap_mode_ff;
   logic        use_super_ff;
   logic [19:0] delay_us_ff;

   logic    q_full, q_push, q_pop, q_head_valid;
   cmd_type q_push_cmd, q_head_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         remap_mode_ff <= MODE_ESC_TO_CAPS;
         use_super_ff  <= 1'b0;
         delay_us_ff   <= DEFAULT_DELAY_US;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_REMAP_MODE: remap_mode_ff <= csr_wdata[1:0];
            CSR_USE_SUPER:  use_super_ff  <= csr_wdata[0];
            CSR_DELAY_US:   delay_us_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   drkr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_ev_type  (req_ev_type),
      .req_ev_code  (req_ev_code),
      .req_ev_value (req_ev_value),
      .remap_mode   (remap_mode_ff),
      .use_super    (use_super_ff),
      .q_full       (q_full),
      .push         (q_push),
      .push_cmd     (q_push_cmd)
   );

   drkr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_push_cmd),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_cmd   (q_head_cmd)
   );

   drkr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (q_head_valid),
      .head_cmd          (q_head_cmd),
      .pop               (q_pop),
      .use_super         (use_super_ff),
      .delay_us          (delay_us_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_type      (rsp_out_type),
      .rsp_out_code      (rsp_out_code),
      .rsp_out_value     (rsp_out_value),
      .rsp_wait_after_us (rsp_wait_after_us),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

[rtl/drkr_checker.sv]
// ----------------------------------------------------------------------------
// drkr_checker
// Port-level checks of the dual-role key remapper, bound to the top level.
// ----------------------------------------------------------------------------
module drkr_checker
   import drkr_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [4:0]         rsp_out_type,
   input logic [9:0]         rsp_out_code,
   input logic signed [31:0] rsp_out_value,
   input logic [19:0]        rsp_wait_after_us,
   input logic               rsp_last_of_run
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_type)
         && $stable(rsp_out_code) && $stable(rsp_out_value)
         && $stable(rsp_wait_after_us) && $stable(rsp_last_of_run))
      else $error("result changed while stalled");

   a_wait_on_sync: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_wait_after_us != 20'd0) |-> rsp_out_type == EVT_SYN)
      else $error("pause on a non-sync event");

   a_pause_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_wait_after_us != 20'd0) |-> !rsp_last_of_run)
      else $error("synthesized sync marked last");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind dual_role_key_remapper_unit drkr_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_out_type      (rsp_out_type),
   .rsp_out_code      (rsp_out_code),
   .rsp_out_value     (rsp_out_value),
   .rsp_wait_after_us (rsp_wait_after_us),
   .rsp_last_of_run   (rsp_last_of_run)
);

[tb/tb_dual_role_key_remapper_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_role_key_remapper_unit
// Self-checking bench for the caps lock tap/hold remapper. A short scripted
// sequence covers reset defaults, taps, holds, scan codes and field extremes.
// Six register settings then drive caps tap and hold sequences, plain keys and
// noise at random. Every result transfer is checked field by field against an
// in-bench model of the caps phase and the escape/grave remapping. Both
// channels see random gaps and stalls, except in the one calm phase.
// ----------------------------------------------------------------------------
module tb_dual_role_key_remapper_unit;
   import drkr_pkg::*;

   localparam logic [1:0] CSR_SPARE      = 2'd3;
   localparam logic [1:0] MODE_PLAIN     = 2'd1;
   localparam logic [1:0] MODE_PLAIN_ALT = 2'd3;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int PHASE_QUOTA    = 23;

   typedef struct {
      logic [4:0]         ev_type;
      logic [9:0]         ev_code;
      logic signed [31:0] ev_value;
      logic [19:0]        wait_us;
      logic               last;
   } emitted_event_type;

   typedef struct {
      logic [4:0]         ev_type;
      logic [9:0]         ev_code;
      logic signed [31:0] ev_value;
      bit                 typed;
      int                 n_out;
      logic [9:0]         last_code;
      logic signed [31:0] last_value;
   } script_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [4:0]         req_ev_type = '0;
   logic [9:0]         req_ev_code = '0;
   logic signed [31:0] req_ev_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [4:0]         rsp_out_type;
   logic [9:0]         rsp_out_code;
   logic signed [31:0] rsp_out_value;
   logic [19:0]        rsp_wait_after_us;
   logic               rsp_last_of_run;
   logic               csr_write = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [19:0]        csr_wdata = '0;

   phase_type         caps_phase_m;
   logic [1:0]        mode_m;
   logic              super_m;
   logic [19:0]       delay_m;
   emitted_event_type due_events[$];

   int n_fail = 0;
   int n_items = 0;
   int n_results = 0;
   int n_taps = 0;
   int n_holds = 0;
   int last_out_count = 0;
   int quiet_cycles = 0;
   int stall_left = 0;
   bit calm = 1'b0;

   dual_role_key_remapper_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_ev_type       (req_ev_type),
      .req_ev_code       (req_ev_code),
      .req_ev_value      (req_ev_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_type      (rsp_out_type),
      .rsp_out_code      (rsp_out_code),
      .rsp_out_value     (rsp_out_value),
      .rsp_wait_after_us (rsp_wait_after_us),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [9:0] pick_code();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) return KEY_ESC;
      if (r < 45) return KEY_BACKTICK;
      if (r < 60) return KEY_CAPS;
      return 10'($urandom);
   endfunction

   function automatic logic signed [31:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 32'sd1;
      if (r < 70) return 32'sd0;
      if (r < 85) return 32'sd2;
      return $urandom;
   endfunction

   function automatic logic signed [31:0] press_value();
      logic signed [31:0] v;
      v = $urandom;
      if ($urandom_range(0, 99) < 70) v = 32'sd1;
      else if (v == 0) v = 32'sd2;
      return v;
   endfunction

   function automatic logic [9:0] mapped_code(input logic [4:0] t, input logic [9:0] c);
      logic [9:0] r;
      r = c;
      if (t == EVT_KEY) begin
         if (mode_m == MODE_ESC_TO_CAPS) begin
            if (c == KEY_ESC) r = KEY_CAPS;
         end else if (mode_m == MODE_ESC_TO_GRAVE) begin
            if (c == KEY_ESC) r = KEY_BACKTICK;
            else if (c == KEY_BACKTICK) r = KEY_CAPS;
         end
      end
      return r;
   endfunction

   function automatic script_row_type row(input logic [4:0] t, input logic [9:0] c,
                                          input logic signed [31:0] v, input bit typed,
                                          input int n, input logic [9:0] lc,
                                          input logic signed [31:0] lv);
      script_row_type s;
      s.ev_type = t;
      s.ev_code = c;
      s.ev_value = v;
      s.typed = typed;
      s.n_out = n;
      s.last_code = lc;
      s.last_value = lv;
      return s;
   endfunction

   task automatic queue_event(input logic [4:0] t, input logic [9:0] c,
                              input logic signed [31:0] v, input logic [19:0] w,
                              input logic last);
      emitted_event_type e;
      e.ev_type = t;
      e.ev_code = c;
      e.ev_value = v;
      e.wait_us = w;
      e.last = last;
      due_events.push_back(e);
   endtask

   task automatic remap_event(input logic [4:0] t, input logic [9:0] c,
                              input logic signed [31:0] v, output int n_out);
      logic       is_caps;
      logic [9:0] mod_key;
      is_caps = (t == EVT_KEY) && (c == KEY_CAPS);
      mod_key = super_m ? KEY_LMETA : KEY_LCTRL;
      n_out = 0;
      if (t == EVT_MSC && c == MSC_SCAN_CODE) return;
      if (t != EVT_KEY && t != EVT_REL && t != EVT_ABS) begin
         queue_event(t, c, v, '0, 1'b1);
         n_out = 1;
         return;
      end
      case (caps_phase_m)
         PH_HELD: begin
            if (is_caps) begin
               if (v == 0) begin
                  queue_event(EVT_KEY, KEY_ESC, 32'sd1, '0, 1'b0);
                  queue_event(EVT_SYN, '0, 32'sd0, delay_m, 1'b0);
                  queue_event(EVT_KEY, KEY_ESC, 32'sd0, '0, 1'b1);
                  caps_phase_m = PH_IDLE;
                  n_out = 3;
                  n_taps++;
               end
            end else if ((t == EVT_KEY && v == 1) || t == EVT_REL || t == EVT_ABS) begin
               queue_event(EVT_KEY, mod_key, 32'sd1, '0, 1'b0);
               queue_event(EVT_SYN, '0, 32'sd0, delay_m, 1'b0);
               queue_event(t, mapped_code(t, c), v, '0, 1'b1);
               caps_phase_m = PH_MOD;
               n_out = 3;
               n_holds++;
            end else begin
               queue_event(t, mapped_code(t, c), v, '0, 1'b1);
               n_out = 1;
            end
         end
         PH_MOD: begin
            if (is_caps) begin
               queue_event(EVT_KEY, mod_key, v, '0, 1'b1);
               if (v == 0) caps_phase_m = PH_IDLE;
            end else begin
               queue_event(t, mapped_code(t, c), v, '0, 1'b1);
            end
            n_out = 1;
         end
         default: begin
            if (is_caps && v != 0) begin
               caps_phase_m = PH_HELD;
            end else begin
               queue_event(t, mapped_code(t, c), v, '0, 1'b1);
               n_out = 1;
            end
         end
      endcase
   endtask

   task automatic send_event(input logic [4:0] t, input logic [9:0] c,
                             input logic signed [31:0] v);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_ev_type <= 5'($urandom);
         req_ev_code <= 10'($urandom);
         req_ev_value <= $urandom;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ev_type <= t;
      req_ev_code <= c;
      req_ev_value <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      remap_event(t, c, v, last_out_count);
      n_items++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (due_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [1:0] mode, input logic sup,
                            input logic [19:0] delay, input bit quiet);
      int start;
      int r;
      csr_write <= 1'b1;
      csr_index <= CSR_REMAP_MODE;
      csr_wdata <= {18'($urandom), mode};
      @(posedge clock);
      csr_index <= CSR_USE_SUPER;
      csr_wdata <= {19'($urandom), sup};
      @(posedge clock);
      csr_index <= CSR_DELAY_US;
      csr_wdata <= delay;
      @(posedge clock);
      csr_index <= CSR_SPARE;
      csr_wdata <= 20'($urandom);
      @(posedge clock);
      csr_write <= 1'b0;
      mode_m = mode;
      super_m = sup;
      delay_m = delay;
      calm = quiet;
      start = n_items;
      while (n_items - start < PHASE_QUOTA) begin
         r = $urandom_range(0, 99);
         if (r < 30) begin
            send_event(EVT_KEY, KEY_CAPS, press_value());
            repeat ($urandom_range(0, 2)) send_event(EVT_KEY, KEY_CAPS, 32'sd2);
            send_event(EVT_KEY, KEY_CAPS, 32'sd0);
         end else if (r < 60) begin
            send_event(EVT_KEY, KEY_CAPS, press_value());
            if ($urandom_range(0, 3) == 0)
               send_event(EVT_KEY, pick_code(), $urandom_range(0, 1) ? 32'sd0 : 32'sd2);
            case ($urandom_range(0, 2))
               0: send_event(EVT_KEY, pick_code(), 32'sd1);
               1: send_event(EVT_REL, 10'($urandom_range(0, 15)), $urandom_range(0, 20) - 10);
               default: send_event(EVT_ABS, 10'($urandom), $urandom);
            endcase
            repeat ($urandom_range(0, 3)) begin
               if ($urandom_range(0, 2) == 0) send_event(EVT_KEY, KEY_CAPS, 32'sd2);
               else send_event(EVT_KEY, pick_code(), pick_value());
            end
            if ($urandom_range(0, 9) != 0) send_event(EVT_KEY, KEY_CAPS, 32'sd0);
         end else if (r < 85) begin
            send_event(EVT_KEY, pick_code(), pick_value());
         end else if (r < 90) begin
            send_event(EVT_MSC, MSC_SCAN_CODE, $urandom);
         end else begin
            send_event(5'($urandom), 10'($urandom), $urandom);
         end
      end
      drain();
   endtask

   task automatic report_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
      if (want !== got) begin
         n_fail++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      emitted_event_type want;
      int gap_len;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_results++;
         if (due_events.size() == 0) begin
            n_fail++;
            $display("%0t: unexpected result, expected none, actual %h/%h/%h", $time,
                     rsp_out_type, rsp_out_code, rsp_out_value);
         end else begin
            want = due_events.pop_front();
            report_field("out_type", 32'(want.ev_type), 32'(rsp_out_type));
            report_field("out_code", 32'(want.ev_code), 32'(rsp_out_code));
            report_field("out_value", want.ev_value, rsp_out_value);
            report_field("wait_after_us", 32'(want.wait_us), 32'(rsp_wait_after_us));
            report_field("last_of_run", 32'(want.last), 32'(rsp_last_of_run));
         end
      end
      if (calm) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         stall_left <= $urandom_range(0, 20);
      end else begin
         gap_len = pick_gap();
         if (gap_len != 0) begin
            rsp_stall <= 1'b1;
            stall_left <= gap_len - 1;
         end else begin
            stall_left <= $urandom_range(0, 6);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles at %0t", quiet_cycles, $time);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      script_row_type script[$];
      emitted_event_type tail;
      caps_phase_m = PH_IDLE;
      mode_m = MODE_ESC_TO_CAPS;
      super_m = 1'b0;
      delay_m = DEFAULT_DELAY_US;

      script.push_back(row(EVT_KEY, KEY_ESC, 32'sd1, 1, 1, KEY_CAPS, 32'sd1));
      script.push_back(row(EVT_KEY, KEY_ESC, 32'sd0, 1, 1, KEY_CAPS, 32'sd0));
      script.push_back(row(EVT_KEY, KEY_CAPS, 32'sd1, 1, 0, '0, 32'sd0));
      script.push_back(row(EVT_KEY, KEY_CAPS, 32'sd2, 1, 0, '0, 32'sd0));
      script.push_back(row(EVT_KEY, KEY_CAPS, 32'sd0, 1, 3, KEY_ESC, 32'sd0));
      script.push_back(row(EVT_KEY, KEY_CAPS, 32'sd1, 0, 0, '0, 32'sd0));
      script.push_back(row(EVT_KEY, 10'd30, 32'sd1, 0, 0, '0, 32'sd0));
      script.push_back(row(EVT_KEY, KEY_CAPS, 32'sd2, 0, 0, '0, 32'sd0));
      script.push_back(row(EVT_KEY, 10'd30, 32'sd0, 0, 0, '0, 32'sd0));
      script.push_back(row(EVT_KEY, KEY_CAPS, 32'sd0, 0, 0, '0, 32'sd0));
      script.push_back(row(EVT_KEY, KEY_CAPS, 32'sd7, 0, 0, '0, 32'sd0));
      script.push_back(row(EVT_KEY, 10'd30, 32'sd0, 0, 0, '0, 32'sd0));
      script.push_back(row(EVT_KEY, 10'd30, 32'sd2, 0, 0, '0, 32'sd0));
      script.push_back(row(EVT_REL, 10'd0, -32'sd5, 0, 0, '0, 32'sd0));
      script.push_back(row(EVT_KEY, KEY_CAPS, 32'sd0, 0, 0, '0, 32'sd0));
      script.push_back(row(EVT_MSC, MSC_SCAN_CODE, 32'sd123, 1, 0, '0, 32'sd0));
      script.push_back(row(EVT_MSC, 10'd3, 32'sd5, 1, 1, 10'd3, 32'sd5));
      script.push_back(row(EVT_SYN, 10'd0, 32'sd0, 1, 1, 10'd0, 32'sd0));
      script.push_back(row(5'd31, 10'd1023, 32'sh7FFFFFFF, 1, 1, 10'd1023, 32'sh7FFFFFFF));
      script.push_back(row(EVT_KEY, 10'd1023, 32'sh80000000, 1, 1, 10'd1023, 32'sh80000000));
      script.push_back(row(EVT_KEY, KEY_CAPS, -32'sd1, 0, 0, '0, 32'sd0));
      script.push_back(row(EVT_ABS, 10'd1023, 32'sh80000000, 0, 0, '0, 32'sd0));
      script.push_back(row(EVT_MSC, MSC_SCAN_CODE, 32'sd0, 1, 0, '0, 32'sd0));
      script.push_back(row(EVT_KEY, KEY_CAPS, 32'sd0, 0, 0, '0, 32'sd0));
      script.push_back(row(EVT_KEY, KEY_BACKTICK, 32'sd1, 1, 1, KEY_BACKTICK, 32'sd1));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         send_event(script[i].ev_type, script[i].ev_code, script[i].ev_value);
         if (script[i].typed) begin
            if (last_out_count != script[i].n_out) begin
               n_fail++;
               $display("%0t: row %0d result count, expected %0d, actual %0d", $time, i,
                        script[i].n_out, last_out_count);
            end else if (last_out_count != 0) begin
               tail = due_events[$];
               if (tail.ev_code !== script[i].last_code
                   || tail.ev_value !== script[i].last_value) begin
                  n_fail++;
                  $display("%0t: row %0d final result, expected %h/%h, actual %h/%h",
                           $time, i, script[i].last_code, script[i].last_value,
                           tail.ev_code, tail.ev_value);
               end
            end
         end
      end
      drain();

      run_phase(MODE_ESC_TO_GRAVE, 1'b1, 20'hFFFFF, 1'b0);
      run_phase(MODE_PLAIN, 1'b0, 20'h00000, 1'b0);
      run_phase(MODE_PLAIN_ALT, 1'b1, 20'h00001, 1'b1);
      run_phase(MODE_ESC_TO_CAPS, 1'b1, 20'($urandom), 1'b0);
      run_phase(MODE_ESC_TO_GRAVE, 1'b0, 20'($urandom), 1'b0);
      run_phase(MODE_ESC_TO_CAPS, 1'b0, DEFAULT_DELAY_US, 1'b0);

      $display("covered %0d events and %0d result transfers over six register settings",
               n_items, n_results);
      $display("caps taps: %0d, caps holds turned modifier: %0d", n_taps, n_holds);
      if (n_fail == 0 && due_events.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
